[hw/rtl/cte_pkg.sv]
// cte_pkg: shared types and constants for the capability table block
// used by cte_ram consumers and capability_table_with_enable_list
`timescale 1ns / 1ps

package cte_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CODE_W      = 32;
   localparam int VENDOR_W    = 32;
   localparam int NAME_W      = 64;
   localparam int TOTAL_W     = 7;
   // entry body layout: {enable, vendor, name}
   localparam int BODY_W      = 1 + VENDOR_W + NAME_W;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_ENABLE = 2'd2;
   localparam logic [1:0] MODE_ORDER  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_BODY_USE,
      ST_ADD_WR,
      ST_MISS,
      ST_LIST_USE
   } state_type;

endpackage

[hw/rtl/cte_ram.sv]
// cte_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/capability_table_with_enable_list.sv]
// capability_table_with_enable_list: capability table with ordered enabled-code list
// depends on cte_pkg and cte_ram
`timescale 1ns / 1ps

// Holds up to cte_pkg::MAX_ENTRIES capability entries (code, vendor and name
// signatures, enable flag) and an ordered list of codes that were enabled.
// Add, lookup and enable search the code store linearly, one stored code per
// cycle through the code ram's single read port; a get-by-order item reads
// the list ram without a search. One item is worked on at a time: req_ready
// is high only while the sequencer is idle. The result sits in an output
// register; a search may run while the previous result waits.

module capability_table_with_enable_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_code,
   input  logic [31:0] req_vendor_sig,
   input  logic [63:0] req_name_sig,
   input  logic [5:0]  req_order_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic        rsp_known,
   output logic        rsp_enabled,
   output logic [31:0] rsp_stored_vendor_sig,
   output logic [63:0] rsp_stored_name_sig,
   output logic [31:0] rsp_code_out,
   output logic [6:0]  rsp_enabled_total
);

   cte_pkg::state_type state_ff, state_in;

   // request capture
   logic [1:0]                    mode_ff, mode_in;
   logic [cte_pkg::CODE_W-1:0]    code_ff, code_in;
   logic [cte_pkg::VENDOR_W-1:0]  vendor_ff, vendor_in;
   logic [cte_pkg::NAME_W-1:0]    name_ff, name_in;
   logic [5:0]                    oi_ff, oi_in;

   // search state
   logic [cte_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic                          pend_ff, pend_in;
   logic [cte_pkg::ADDR_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                          found_ff, found_in;
   logic [cte_pkg::ADDR_W-1:0]    slot_ff, slot_in;

   logic [cte_pkg::CNT_W-1:0]     entry_count_ff, entry_count_in;
   logic [cte_pkg::CNT_W-1:0]     en_count_ff, en_count_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic                          rsp_known_ff, rsp_known_in;
   logic                          rsp_enabled_ff, rsp_enabled_in;
   logic [cte_pkg::VENDOR_W-1:0]  rsp_vendor_ff, rsp_vendor_in;
   logic [cte_pkg::NAME_W-1:0]    rsp_name_ff, rsp_name_in;
   logic [cte_pkg::CODE_W-1:0]    rsp_code_ff, rsp_code_in;
   logic [cte_pkg::TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;

   // ram ports
   logic                          code_wr_en;
   logic [cte_pkg::ADDR_W-1:0]    code_rd_addr;
   logic [cte_pkg::CODE_W-1:0]    code_rd_data;
   logic                          body_wr_en;
   logic [cte_pkg::ADDR_W-1:0]    body_wr_addr;
   logic [cte_pkg::BODY_W-1:0]    body_wr_data;
   logic [cte_pkg::ADDR_W-1:0]    body_rd_addr;
   logic [cte_pkg::BODY_W-1:0]    body_rd_data;
   logic                          list_wr_en;
   logic [cte_pkg::ADDR_W-1:0]    list_rd_addr;
   logic [cte_pkg::CODE_W-1:0]    list_rd_data;

   logic                          req_beat;
   logic                          out_free;
   logic                          hit;
   logic                          more;
   logic                          table_room;
   logic                          list_room;
   logic                          body_enable;
   logic [cte_pkg::VENDOR_W-1:0]  body_vendor;
   logic [cte_pkg::NAME_W-1:0]    body_name;
   logic                          sig_match;
   logic                          oi_valid;
   logic [cte_pkg::ADDR_W-1:0]    add_slot;

   assign req_ready  = (state_ff == cte_pkg::ST_IDLE);
   assign req_beat   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign hit        = pend_ff && (code_rd_data == code_ff);
   assign more       = (idx_ff < entry_count_ff);
   assign table_room = (entry_count_ff < cte_pkg::CNT_W'(cte_pkg::MAX_ENTRIES));
   assign list_room  = (en_count_ff < cte_pkg::CNT_W'(cte_pkg::MAX_ENTRIES));
   assign {body_enable, body_vendor, body_name} = body_rd_data;
   assign sig_match  = (body_vendor == vendor_ff) && (body_name == name_ff) && list_room;
   assign oi_valid   = ({1'b0, oi_ff} < en_count_ff);
   assign add_slot   = found_ff ? slot_ff : entry_count_ff[cte_pkg::ADDR_W-1:0];

   // the code store is read at the scan index while searching
   assign code_rd_addr = idx_ff[cte_pkg::ADDR_W-1:0];
   // body read follows the pending compare so data is ready on a hit
   assign body_rd_addr = (state_ff == cte_pkg::ST_SEARCH) ? pend_idx_ff : slot_ff;
   assign list_rd_addr = (state_ff == cte_pkg::ST_IDLE) ?
                         cte_pkg::ADDR_W'(req_order_index) : cte_pkg::ADDR_W'(oi_ff);

   cte_ram #(.WIDTH(cte_pkg::CODE_W), .DEPTH(cte_pkg::MAX_ENTRIES)) u_code_ram (
      .clock   (clock),
      .wr_en   (code_wr_en),
      .wr_addr (add_slot),
      .wr_data (code_ff),
      .rd_addr (code_rd_addr),
      .rd_data (code_rd_data)
   );

   cte_ram #(.WIDTH(cte_pkg::BODY_W), .DEPTH(cte_pkg::MAX_ENTRIES)) u_body_ram (
      .clock   (clock),
      .wr_en   (body_wr_en),
      .wr_addr (body_wr_addr),
      .wr_data (body_wr_data),
      .rd_addr (body_rd_addr),
      .rd_data (body_rd_data)
   );

   cte_ram #(.WIDTH(cte_pkg::CODE_W), .DEPTH(cte_pkg::MAX_ENTRIES)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (en_count_ff[cte_pkg::ADDR_W-1:0]),
      .wr_data (code_ff),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cte_pkg::ST_IDLE: begin
            if (req_beat) begin
               state_in = (req_mode == cte_pkg::MODE_ORDER) ?
                          cte_pkg::ST_LIST_USE : cte_pkg::ST_SEARCH;
            end
         end
         cte_pkg::ST_SEARCH: begin
            if (hit) begin
               state_in = (mode_ff == cte_pkg::MODE_ADD) ?
                          cte_pkg::ST_ADD_WR : cte_pkg::ST_BODY_USE;
            end else if (!more) begin
               state_in = (mode_ff == cte_pkg::MODE_ADD) ?
                          cte_pkg::ST_ADD_WR : cte_pkg::ST_MISS;
            end
         end
         cte_pkg::ST_BODY_USE,
         cte_pkg::ST_ADD_WR,
         cte_pkg::ST_MISS,
         cte_pkg::ST_LIST_USE: begin
            if (out_free) begin
               state_in = cte_pkg::ST_IDLE;
            end
         end
         default: state_in = cte_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in        = mode_ff;
      code_in        = code_ff;
      vendor_in      = vendor_ff;
      name_in        = name_ff;
      oi_in          = oi_ff;
      idx_in         = idx_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      found_in       = found_ff;
      slot_in        = slot_ff;
      entry_count_in = entry_count_ff;
      en_count_in    = en_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_ok_in      = rsp_ok_ff;
      rsp_known_in   = rsp_known_ff;
      rsp_enabled_in = rsp_enabled_ff;
      rsp_vendor_in  = rsp_vendor_ff;
      rsp_name_in    = rsp_name_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_total_in   = rsp_total_ff;
      code_wr_en     = 1'b0;
      body_wr_en     = 1'b0;
      body_wr_addr   = slot_ff;
      body_wr_data   = {1'b0, vendor_ff, name_ff};
      list_wr_en     = 1'b0;

      case (state_ff)
         cte_pkg::ST_IDLE: begin
            if (req_beat) begin
               mode_in   = req_mode;
               code_in   = req_code;
               vendor_in = req_vendor_sig;
               name_in   = req_name_sig;
               oi_in     = req_order_index;
               idx_in    = '0;
               pend_in   = 1'b0;
               found_in  = 1'b0;
            end
         end
         cte_pkg::ST_SEARCH: begin
            if (hit) begin
               found_in = 1'b1;
               slot_in  = pend_idx_ff;
            end else if (more) begin
               // the read issued now is compared next cycle
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[cte_pkg::ADDR_W-1:0];
               idx_in      = idx_ff + 1'b1;
            end else begin
               found_in = 1'b0;
            end
         end
         cte_pkg::ST_ADD_WR: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_enabled_in = 1'b0;
               rsp_code_in    = '0;
               if (found_ff || table_room) begin
                  body_wr_en    = 1'b1;
                  body_wr_addr  = add_slot;
                  body_wr_data  = {1'b0, vendor_ff, name_ff};
                  rsp_ok_in     = 1'b1;
                  rsp_known_in  = 1'b1;
                  rsp_vendor_in = vendor_ff;
                  rsp_name_in   = name_ff;
               end else begin
                  rsp_ok_in     = 1'b0;
                  rsp_known_in  = 1'b0;
                  rsp_vendor_in = '0;
                  rsp_name_in   = '0;
               end
               if (!found_ff && table_room) begin
                  code_wr_en     = 1'b1;
                  entry_count_in = entry_count_ff + 1'b1;
               end
               rsp_total_in = cte_pkg::TOTAL_W'(en_count_ff);
            end
         end
         cte_pkg::ST_BODY_USE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_known_in  = 1'b1;
               rsp_vendor_in = body_vendor;
               rsp_name_in   = body_name;
               rsp_code_in   = '0;
               rsp_total_in  = cte_pkg::TOTAL_W'(en_count_ff);
               if (mode_ff == cte_pkg::MODE_ENABLE) begin
                  body_wr_en     = 1'b1;
                  body_wr_data   = {sig_match, body_vendor, body_name};
                  rsp_ok_in      = sig_match;
                  rsp_enabled_in = sig_match;
                  if (sig_match) begin
                     list_wr_en   = 1'b1;
                     en_count_in  = en_count_ff + 1'b1;
                     rsp_total_in = cte_pkg::TOTAL_W'(en_count_ff + 1'b1);
                  end
               end else begin
                  rsp_ok_in      = 1'b1;
                  rsp_enabled_in = body_enable;
               end
            end
         end
         cte_pkg::ST_MISS: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_ok_in      = 1'b0;
               rsp_known_in   = 1'b0;
               rsp_enabled_in = 1'b0;
               rsp_vendor_in  = '0;
               rsp_name_in    = '0;
               rsp_code_in    = '0;
               rsp_total_in   = cte_pkg::TOTAL_W'(en_count_ff);
            end
         end
         cte_pkg::ST_LIST_USE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_ok_in      = oi_valid;
               rsp_known_in   = 1'b0;
               rsp_enabled_in = 1'b0;
               rsp_vendor_in  = '0;
               rsp_name_in    = '0;
               rsp_code_in    = oi_valid ? list_rd_data : '0;
               rsp_total_in   = cte_pkg::TOTAL_W'(en_count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= cte_pkg::ST_IDLE;
         pend_ff        <= 1'b0;
         found_ff       <= 1'b0;
         entry_count_ff <= '0;
         en_count_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_ff        <= pend_in;
         found_ff       <= found_in;
         entry_count_ff <= entry_count_in;
         en_count_ff    <= en_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      code_ff        <= code_in;
      vendor_ff      <= vendor_in;
      name_ff        <= name_in;
      oi_ff          <= oi_in;
      idx_ff         <= idx_in;
      pend_idx_ff    <= pend_idx_in;
      slot_ff        <= slot_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_known_ff   <= rsp_known_in;
      rsp_enabled_ff <= rsp_enabled_in;
      rsp_vendor_ff  <= rsp_vendor_in;
      rsp_name_ff    <= rsp_name_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_ok                = rsp_ok_ff;
   assign rsp_known             = rsp_known_ff;
   assign rsp_enabled           = rsp_enabled_ff;
   assign rsp_stored_vendor_sig = rsp_vendor_ff;
   assign rsp_stored_name_sig   = rsp_name_ff;
   assign rsp_code_out          = rsp_code_ff;
   assign rsp_enabled_total     = rsp_total_ff;

   // counts never pass the table depth
   a_entry_count_max: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= cte_pkg::CNT_W'(cte_pkg::MAX_ENTRIES))
      else $error("entry count above table depth");

   a_en_count_max: assert property (@(posedge clock) disable iff (reset)
      en_count_ff <= cte_pkg::CNT_W'(cte_pkg::MAX_ENTRIES))
      else $error("enabled list count above depth");

   // a new result beat only comes out of a finishing state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |->
      ($past(state_ff) != cte_pkg::ST_IDLE && $past(state_ff) != cte_pkg::ST_SEARCH))
      else $error("result beat raised outside a finishing state");

   // get-by-order results never report a table entry
   a_order_no_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_code_ff != '0) |-> (!rsp_known_ff && !rsp_enabled_ff))
      else $error("order result carries entry fields");

endmodule

[tb/sv/tb.sv]
// tb: self-checking bench for capability_table_with_enable_list
// depends on cte_pkg and the block's rtl; predicts each result beat from a local table copy
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_ITEMS  = 1080;
   localparam int POOL_SIZE     = 80;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 80;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] code;
      logic [31:0] vendor;
      logic [63:0] name;
      logic [5:0]  idx;
   } cap_req_type;

   typedef struct packed {
      logic        ok;
      logic        known;
      logic        enabled;
      logic [31:0] vendor;
      logic [63:0] name;
      logic [31:0] code_out;
      logic [6:0]  total;
   } cap_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [31:0] req_code = '0;
   logic [31:0] req_vendor_sig = '0;
   logic [63:0] req_name_sig = '0;
   logic [5:0]  req_order_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ok;
   logic        rsp_known;
   logic        rsp_enabled;
   logic [31:0] rsp_stored_vendor_sig;
   logic [63:0] rsp_stored_name_sig;
   logic [31:0] rsp_code_out;
   logic [6:0]  rsp_enabled_total;

   capability_table_with_enable_list u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_code              (req_code),
      .req_vendor_sig        (req_vendor_sig),
      .req_name_sig          (req_name_sig),
      .req_order_index       (req_order_index),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_ok                (rsp_ok),
      .rsp_known             (rsp_known),
      .rsp_enabled           (rsp_enabled),
      .rsp_stored_vendor_sig (rsp_stored_vendor_sig),
      .rsp_stored_name_sig   (rsp_stored_name_sig),
      .rsp_code_out          (rsp_code_out),
      .rsp_enabled_total     (rsp_enabled_total)
   );

   cap_req_type pending_req[$];
   cap_rsp_type expected_rsp[$];
   int          total_n = 0;
   int          req_beats = 0;
   int          phase_now;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          mismatch_n = 0;
   int          hold_left = 0;
   logic        pressure_done = 1'b0;
   longint      cyc_n = 0;

   // local copy of the capability table and the enabled list
   logic [31:0] tbl_code[cte_pkg::MAX_ENTRIES];
   logic [31:0] tbl_vendor[cte_pkg::MAX_ENTRIES];
   logic [63:0] tbl_name[cte_pkg::MAX_ENTRIES];
   logic        tbl_en[cte_pkg::MAX_ENTRIES];
   int          tbl_count = 0;
   logic [31:0] list_code[cte_pkg::MAX_ENTRIES];
   int          list_count = 0;

   // stimulus-side shadow of what the table holds, used to build matching enables
   logic [31:0] gen_codes[$];
   logic [31:0] gen_vendor[logic [31:0]];
   logic [63:0] gen_name[logic [31:0]];
   logic [31:0] code_pool[POOL_SIZE];

   function automatic cap_rsp_type table_apply(cap_req_type r);
      cap_rsp_type o;
      int slot;
      int i;
      o = '0;
      slot = -1;
      if (r.mode != cte_pkg::MODE_ORDER) begin
         for (i = 0; i < tbl_count; i++)
            if (slot < 0 && tbl_code[i] == r.code) slot = i;
      end
      case (r.mode)
         cte_pkg::MODE_ADD: begin
            if (slot < 0 && tbl_count < cte_pkg::MAX_ENTRIES) begin
               slot = tbl_count;
               tbl_count++;
               tbl_code[slot] = r.code;
            end
            if (slot >= 0) begin
               tbl_vendor[slot] = r.vendor;
               tbl_name[slot]   = r.name;
               tbl_en[slot]     = 1'b0;
               o.ok = 1'b1;
            end
         end
         cte_pkg::MODE_LOOKUP: begin
            o.ok = (slot >= 0);
         end
         cte_pkg::MODE_ENABLE: begin
            if (slot >= 0) begin
               if (tbl_vendor[slot] != r.vendor || tbl_name[slot] != r.name ||
                   list_count >= cte_pkg::MAX_ENTRIES) begin
                  tbl_en[slot] = 1'b0;
               end else begin
                  tbl_en[slot] = 1'b1;
                  list_code[list_count] = r.code;
                  list_count++;
                  o.ok = 1'b1;
               end
            end
         end
         default: begin
            if (int'(r.idx) < list_count) begin
               o.ok       = 1'b1;
               o.code_out = list_code[r.idx];
            end
         end
      endcase
      if (slot >= 0) begin
         o.known   = 1'b1;
         o.enabled = tbl_en[slot];
         o.vendor  = tbl_vendor[slot];
         o.name    = tbl_name[slot];
      end
      o.total = 7'(list_count);
      return o;
   endfunction

   task automatic queue_item(input logic [1:0] mode, input logic [31:0] code,
                             input logic [31:0] vendor, input logic [63:0] name,
                             input logic [5:0] idx);
      cap_req_type r;
      r.mode   = mode;
      r.code   = code;
      r.vendor = vendor;
      r.name   = name;
      r.idx    = idx;
      pending_req.push_back(r);
      if (mode == cte_pkg::MODE_ADD) begin
         if (!gen_vendor.exists(code) && gen_codes.size() < cte_pkg::MAX_ENTRIES)
            gen_codes.push_back(code);
         if (gen_vendor.exists(code) || gen_codes.size() <= cte_pkg::MAX_ENTRIES) begin
            if (gen_vendor.exists(code) || gen_codes[gen_codes.size() - 1] == code) begin
               gen_vendor[code] = vendor;
               gen_name[code]   = name;
            end
         end
      end
   endtask

   task automatic check_field(input string fname, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
         mismatch_n++;
      end
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cyc_n <= cyc_n + 1;
      if (cyc_n >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always_comb begin
      phase_now = (total_n > 0) ? (req_beats * 5) / total_n : 0;
      send_idle_pct  = (phase_now == 1) ? 45 : (phase_now == 3) ? 18 : 0;
      recv_stall_pct = (phase_now == 2) ? 45 : (phase_now == 3) ? 18 : 0;
   end

   // driver: prediction is taken at the accepting edge, then the next beat is offered
   always @(posedge clock) begin : drive
      cap_req_type nxt;
      cap_req_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            cur.mode   = req_mode;
            cur.code   = req_code;
            cur.vendor = req_vendor_sig;
            cur.name   = req_name_sig;
            cur.idx    = req_order_index;
            expected_rsp.push_back(table_apply(cur));
            req_beats <= req_beats + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_req.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_req.pop_front();
               req_valid       <= 1'b1;
               req_mode        <= nxt.mode;
               req_code        <= nxt.code;
               req_vendor_sig  <= nxt.vendor;
               req_name_sig    <= nxt.name;
               req_order_index <= nxt.idx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off once, so the block fills up and drops req_ready
   always @(posedge clock) begin : pressure
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (phase_now == 4 && !pressure_done) begin
         hold_left     <= HOLD_CYCLES;
         pressure_done <= 1'b1;
      end
   end

   // monitor: compares each result beat and drives rsp_ready
   always @(posedge clock) begin : observe
      cap_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: result beat mismatch, expected no beat, got ok=%0b code_out=%0h",
                        $time, rsp_ok, rsp_code_out);
               mismatch_n++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("ok", 64'(want.ok), 64'(rsp_ok));
               check_field("known", 64'(want.known), 64'(rsp_known));
               check_field("enabled", 64'(want.enabled), 64'(rsp_enabled));
               check_field("stored_vendor_sig", 64'(want.vendor), 64'(rsp_stored_vendor_sig));
               check_field("stored_name_sig", want.name, rsp_stored_name_sig);
               check_field("code_out", 64'(want.code_out), 64'(rsp_code_out));
               check_field("enabled_total", 64'(want.total), 64'(rsp_enabled_total));
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin : stimulus
      logic [1:0]  mode;
      logic [31:0] code;
      logic [31:0] vendor;
      logic [63:0] name;
      int          pick;
      int          n;

      code_pool[0] = 32'h0;
      code_pool[1] = 32'hFFFF_FFFF;
      code_pool[2] = 32'hA5A5_A5A5;
      for (n = 3; n < POOL_SIZE; n++) code_pool[n] = $urandom;

      // empty table and list
      queue_item(cte_pkg::MODE_LOOKUP, 32'h0, 32'h0, 64'h0, 6'd0);
      queue_item(cte_pkg::MODE_ORDER, 32'h0, 32'h0, 64'h0, 6'd0);
      queue_item(cte_pkg::MODE_ENABLE, 32'h1234_5678, 32'h0, 64'h0, 6'd0);
      // extremes of code and signatures
      queue_item(cte_pkg::MODE_ADD, 32'h0, 32'h0, 64'h0, 6'd0);
      queue_item(cte_pkg::MODE_ADD, '1, '1, '1, 6'd63);
      queue_item(cte_pkg::MODE_LOOKUP, 32'h0, '1, '1, 6'd63);
      queue_item(cte_pkg::MODE_LOOKUP, '1, 32'h0, 64'h0, 6'd0);
      // signature mismatches, then a match and a duplicate enable
      queue_item(cte_pkg::MODE_ENABLE, '1, 32'hFFFF_FFFE, '1, 6'd0);
      queue_item(cte_pkg::MODE_ENABLE, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0);
      queue_item(cte_pkg::MODE_ENABLE, '1, '1, '1, 6'd0);
      queue_item(cte_pkg::MODE_ENABLE, '1, '1, '1, 6'd0);
      queue_item(cte_pkg::MODE_ENABLE, 32'h0, 32'h0, 64'h0, 6'd0);
      // order reads, inside and outside the list
      queue_item(cte_pkg::MODE_ORDER, 32'h0, 32'h0, 64'h0, 6'd0);
      queue_item(cte_pkg::MODE_ORDER, 32'h0, 32'h0, 64'h0, 6'd2);
      queue_item(cte_pkg::MODE_ORDER, 32'h0, 32'h0, 64'h0, 6'd3);
      queue_item(cte_pkg::MODE_ORDER, '1, '1, '1, 6'd63);
      // re-add of a known code clears its flag, list stays
      queue_item(cte_pkg::MODE_ADD, '1, 32'h1357_9BDF, 64'h0246_8ACE_1357_9BDF, 6'd0);
      queue_item(cte_pkg::MODE_LOOKUP, '1, 32'h0, 64'h0, 6'd0);
      queue_item(cte_pkg::MODE_ORDER, 32'h0, 32'h0, 64'h0, 6'd1);
      queue_item(cte_pkg::MODE_ADD, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                 64'h5A5A_5A5A_5A5A_5A5A, 6'd21);
      queue_item(cte_pkg::MODE_ENABLE, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                 64'h5A5A_5A5A_5A5A_5A5A, 6'd42);
      queue_item(cte_pkg::MODE_LOOKUP, 32'h1234_5678, 32'h0, 64'h0, 6'd0);

      // random part: a pool of codes bigger than the table, so it fills and refuses adds
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         mode = (pick < 30) ? cte_pkg::MODE_ADD : (pick < 50) ? cte_pkg::MODE_LOOKUP :
                (pick < 80) ? cte_pkg::MODE_ENABLE : cte_pkg::MODE_ORDER;
         pick = $urandom_range(99);
         if (pick < 88) code = code_pool[$urandom_range(POOL_SIZE - 1)];
         else if (pick < 96) code = $urandom;
         else code = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         vendor = $urandom;
         name   = {$urandom, $urandom};
         if (mode == cte_pkg::MODE_ENABLE) begin
            if (gen_codes.size() > 0 && $urandom_range(99) < 80)
               code = gen_codes[$urandom_range(gen_codes.size() - 1)];
            if (gen_vendor.exists(code) && $urandom_range(99) < 75) begin
               vendor = gen_vendor[code];
               name   = gen_name[code];
               // a single flipped bit makes a near-miss signature
               if ($urandom_range(99) < 15) begin
                  if ($urandom_range(1)) vendor[$urandom_range(31)] ^= 1'b1;
                  else name[$urandom_range(63)] ^= 1'b1;
               end
            end
         end
         queue_item(mode, code, vendor, name, 6'($urandom_range(63)));
      end
      total_n = pending_req.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_n == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
